@@ rtl/core/string_record_ring_queue_top_defines.svh @@
// assertion helpers for the string record ring queue
`ifndef STRING_RECORD_RING_QUEUE_TOP_DEFINES_SVH
`define STRING_RECORD_RING_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SRRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srrq check failed");

// next-cycle implication
`define SRRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srrq check failed");

`endif

@@ rtl/core/srrq_pkg.sv @@
`default_nettype none
package srrq_pkg;
	localparam int unsigned RING_DEPTH_DEF = 1024;
	localparam int unsigned CAP_W          = 11;
	localparam int unsigned CAP_RESET      = 1024;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned CMD_W          = 2;
	localparam int unsigned KIND_W         = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;
endpackage
`default_nettype wire

@@ rtl/core/srrq_ifs.sv @@
`default_nettype none
interface srrq_req_if;
	import srrq_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] byte_in;
	modport source (output valid, output cmd, output byte_in, input ready);
	modport sink   (input valid, input cmd, input byte_in, output ready);
endinterface

interface srrq_rsp_if;
	import srrq_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [BYTE_W-1:0] byte_out;
	logic              accepted;
	logic              last;
	modport source (output valid, output result_kind, output byte_out, output accepted,
		output last, input ready);
	modport sink   (input valid, input result_kind, input byte_out, input accepted,
		input last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/srrq_ring.sv @@
`default_nettype none
module srrq_ring #(
	parameter int unsigned DEPTH = srrq_pkg::RING_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(DEPTH)-1:0]       waddr,
	input  wire logic [srrq_pkg::BYTE_W-1:0]    wdata,
	input  wire logic                           re,
	input  wire logic [$clog2(DEPTH)-1:0]       raddr,
	output logic      [srrq_pkg::BYTE_W-1:0]    rdata
);
	import srrq_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/string_record_ring_queue_top.sv @@
// push and clear: one beat per cycle when not stalled; terminator status beat is next cycle
// pop: a ring read holds off all requests while pending; so does an output beat not yet taken
// pop data: ring read register, then output register; empty-queue result: output register only
// output register lets the next beat enter in the cycle the result is taken
// arst_n clears pointers, counts and the drop flag, and sets capacity to 1024 (clamped)
// ring memory contents are not cleared; no clearing pass
`default_nettype none
`include "string_record_ring_queue_top_defines.svh"
module string_record_ring_queue_top #(
	parameter int unsigned RING_DEPTH = srrq_pkg::RING_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	srrq_req_if.sink                        req,
	srrq_rsp_if.source                      rsp,
	input  wire logic                       cfg_we,
	input  wire logic [srrq_pkg::CAP_W-1:0] cfg_wdata
);
	import srrq_pkg::*;

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam int unsigned CAP_RESET_EFF = (CAP_RESET > RING_DEPTH) ? RING_DEPTH : CAP_RESET;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + CNT_W'(1);
		return (n >= cap) ? '0 : PTR_W'(n);
	endfunction

	logic [PTR_W-1:0]  head_q, tail_q, pend_ptr_q;
	logic [CNT_W-1:0]  used_q, pend_cnt_q, cap_q;
	logic              ovf_q;
	logic              rd_pend_s1;
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_acc_q;
	logic              out_last_q;

	logic              in_acc, out_acc;
	logic [CNT_W:0]    fill_sum;
	logic              room_byte, room_term;
	logic              is_push, is_pop, is_clear, is_term;
	logic              wr_en, rd_en;
	logic [BYTE_W-1:0] rd_data;
	logic [31:0]       cfg_ext;
	logic [CNT_W-1:0]  cap_new;

	assign req.ready = !rd_pend_s1 && (!out_valid_q || rsp.ready);
	assign in_acc    = req.valid && req.ready;
	assign out_acc   = rsp.valid && rsp.ready;

	assign is_push  = in_acc && (req.cmd == CMD_PUSH);
	assign is_pop   = in_acc && (req.cmd == CMD_POP);
	assign is_clear = in_acc && (req.cmd == CMD_CLEAR);
	assign is_term  = (req.byte_in == '0);

	assign fill_sum  = {1'b0, used_q} + {1'b0, pend_cnt_q};
	assign room_byte = (fill_sum + (CNT_W+1)'(2)) <= {1'b0, cap_q};
	assign room_term = (fill_sum + (CNT_W+1)'(1)) <= {1'b0, cap_q};

	assign wr_en = is_push && !ovf_q && (is_term ? room_term : room_byte);
	assign rd_en = is_pop && (used_q != '0);

	assign cfg_ext = 32'(cfg_wdata);
	always_comb begin
		priority if (cfg_ext < 32'd2) begin
			cap_new = CNT_W'(2);
		end else if (cfg_ext > 32'(RING_DEPTH)) begin
			cap_new = CNT_W'(RING_DEPTH);
		end else begin
			cap_new = CNT_W'(cfg_ext);
		end
	end

	srrq_ring #(.DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pend_ptr_q),
		.wdata (req.byte_in),
		.re    (rd_en),
		.raddr (head_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			pend_ptr_q  <= '0;
			used_q      <= '0;
			pend_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			cap_q       <= CNT_W'(CAP_RESET_EFF);
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (rd_pend_s1 || (is_push && is_term) || (is_pop && used_q == '0)) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cap_q      <= cap_new;
				head_q     <= '0;
				tail_q     <= '0;
				pend_ptr_q <= '0;
				used_q     <= '0;
				pend_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end else if (is_clear) begin
				head_q     <= '0;
				tail_q     <= '0;
				pend_ptr_q <= '0;
				used_q     <= '0;
				pend_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end else if (rd_en) begin
				head_q <= wrap_inc(head_q, cap_q);
				used_q <= used_q - CNT_W'(1);
			end else if (is_push && !is_term) begin
				if (!ovf_q) begin
					if (room_byte) begin
						pend_ptr_q <= wrap_inc(pend_ptr_q, cap_q);
						pend_cnt_q <= pend_cnt_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end else if (is_push) begin
				if (wr_en) begin
					pend_ptr_q <= wrap_inc(pend_ptr_q, cap_q);
					tail_q     <= wrap_inc(pend_ptr_q, cap_q);
					used_q     <= used_q + pend_cnt_q + CNT_W'(1);
				end else begin
					pend_ptr_q <= tail_q;
				end
				pend_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_kind_q <= KIND_BYTE;
			out_byte_q <= rd_data;
			out_acc_q  <= 1'b0;
			out_last_q <= (rd_data == '0);
		end else if (is_push && is_term) begin
			out_kind_q <= KIND_STATUS;
			out_byte_q <= '0;
			out_acc_q  <= wr_en;
			out_last_q <= 1'b0;
		end else if (is_pop && used_q == '0) begin
			out_kind_q <= KIND_EMPTY;
			out_byte_q <= '0;
			out_acc_q  <= 1'b0;
			out_last_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.byte_out    = out_byte_q;
	assign rsp.accepted    = out_acc_q;
	assign rsp.last        = out_last_q;

	`SRRQ_ASSERT_NEXT(a_pop_reads, clk, arst_n, rd_en, rd_pend_s1 && !req.ready)
	`SRRQ_ASSERT_NEXT(a_pop_delivers, clk, arst_n, rd_pend_s1,
		out_valid_q && out_kind_q == KIND_BYTE)
	`SRRQ_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_sum <= {1'b0, cap_q})
endmodule
`default_nettype wire

@@ sim/string_record_ring_queue_checker.sv @@
`default_nettype none
module string_record_ring_queue_checker #(
	parameter int unsigned DEPTH = srrq_pkg::RING_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	input  wire logic                        req_ready,
	input  wire logic [srrq_pkg::CMD_W-1:0]  req_cmd,
	input  wire logic [srrq_pkg::BYTE_W-1:0] req_byte,
	input  wire logic                        rsp_valid,
	input  wire logic                        rsp_ready,
	input  wire logic [srrq_pkg::KIND_W-1:0] rsp_kind,
	input  wire logic [srrq_pkg::BYTE_W-1:0] rsp_byte,
	input  wire logic                        rsp_accepted,
	input  wire logic                        rsp_last,
	input  wire logic                        cfg_we,
	input  wire logic [srrq_pkg::CAP_W-1:0]  cfg_wdata,
	output int                               fail_count,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import srrq_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic              acc;
		logic              last;
	} rsp_beat_t;

	logic [BYTE_W-1:0] ring_mem [DEPTH];
	logic [PTR_W-1:0]  head_ptr;
	logic [PTR_W-1:0]  tail_ptr;
	logic [PTR_W-1:0]  open_ptr;
	logic [CAP_W-1:0]  used_cnt;
	logic [CAP_W-1:0]  open_cnt;
	logic              dropping;
	logic [CAP_W-1:0]  cap_reg;
	rsp_beat_t         expected_beats [$];
	int                mismatches = 0;
	int                waiting = 0;

	assign fail_count  = mismatches;
	assign outstanding = waiting;

	function automatic int unsigned ring_size();
		int unsigned c;
		c = 32'(cap_reg);
		if (c < 2) c = 2;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (32'(p) + 1 >= ring_size()) ? '0 : p + 1'b1;
	endfunction

	function automatic void empty_ring();
		head_ptr = '0;
		tail_ptr = '0;
		open_ptr = '0;
		used_cnt = '0;
		open_cnt = '0;
		dropping = 1'b0;
	endfunction

	function automatic void predict_command(input logic [CMD_W-1:0] cmd,
		input logic [BYTE_W-1:0] b);
		rsp_beat_t   beat;
		int unsigned room;
		room = ring_size();
		beat = '0;
		unique case (cmd)
			CMD_PUSH: begin
				if (b != '0) begin
					// byte plus terminator must still fit, else drop the whole string
					if (!dropping) begin
						if (32'(used_cnt) + 32'(open_cnt) + 2 > room) begin
							dropping = 1'b1;
						end else begin
							ring_mem[open_ptr] = b;
							open_ptr = next_slot(open_ptr);
							open_cnt = open_cnt + 1'b1;
						end
					end
				end else if (dropping || 32'(used_cnt) + 32'(open_cnt) + 1 > room) begin
					dropping = 1'b0;
					open_ptr = tail_ptr;
					open_cnt = '0;
					beat.kind = KIND_STATUS;
					expected_beats.push_back(beat);
				end else begin
					ring_mem[open_ptr] = '0;
					open_ptr = next_slot(open_ptr);
					used_cnt = used_cnt + open_cnt + 1'b1;
					tail_ptr = open_ptr;
					open_cnt = '0;
					beat.kind = KIND_STATUS;
					beat.acc = 1'b1;
					expected_beats.push_back(beat);
				end
			end
			CMD_POP: begin
				if (used_cnt == '0) begin
					beat.kind = KIND_EMPTY;
				end else begin
					beat.kind = KIND_BYTE;
					beat.data = ring_mem[head_ptr];
					beat.last = (ring_mem[head_ptr] == '0);
					head_ptr = next_slot(head_ptr);
					used_cnt = used_cnt - 1'b1;
				end
				expected_beats.push_back(beat);
			end
			CMD_CLEAR: begin
				empty_ring();
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			cap_reg = CAP_W'(CAP_RESET);
			empty_ring();
			expected_beats.delete();
		end else begin
			if (cfg_we) begin
				cap_reg = cfg_wdata;
				empty_ring();
			end
			// result beats first: nothing accepted on this edge can answer on it
			if (rsp_valid && rsp_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat kind %0d byte %02h",
						rsp_kind, rsp_byte));
				end else begin
					want = expected_beats.pop_front();
					if (rsp_kind !== want.kind)
						report_mismatch($sformatf("result_kind got %0d want %0d",
							rsp_kind, want.kind));
					if (rsp_byte !== want.data)
						report_mismatch($sformatf("byte_out got %02h want %02h",
							rsp_byte, want.data));
					if (rsp_accepted !== want.acc)
						report_mismatch($sformatf("accepted got %0b want %0b",
							rsp_accepted, want.acc));
					if (rsp_last !== want.last)
						report_mismatch($sformatf("last got %0b want %0b",
							rsp_last, want.last));
				end
			end
			if (req_valid && req_ready) predict_command(req_cmd, req_byte);
		end
		waiting = expected_beats.size();
	end
endmodule
`default_nettype wire

@@ sim/tb_string_record_ring_queue_top.sv @@
`default_nettype none
module tb_string_record_ring_queue_top;
	timeunit 1ns;
	timeprecision 1ps;
	import srrq_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned QUIET_LIMIT = 4000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               fail_count;
	int               outstanding;
	bit               calm = 1'b0;
	bit               hold_req = 1'b0;
	int unsigned      quiet_cycles = 0;

	srrq_req_if req_bus ();
	srrq_rsp_if rsp_bus ();

	string_record_ring_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	string_record_ring_queue_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_bus.valid),
		.req_ready    (req_bus.ready),
		.req_cmd      (req_bus.cmd),
		.req_byte     (req_bus.byte_in),
		.rsp_valid    (rsp_bus.valid),
		.rsp_ready    (rsp_bus.ready),
		.rsp_kind     (rsp_bus.result_kind),
		.rsp_byte     (rsp_bus.byte_out),
		.rsp_accepted (rsp_bus.accepted),
		.rsp_last     (rsp_bus.last),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_string_record_ring_queue_top NOT OK");
				$finish;
			end
		end
	end

	// result side: random stall bursts, one long hold on request
	initial begin
		int unsigned stall;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (!calm && $urandom_range(9) == 0) begin
				stall = $urandom_range(19, 1);
			end else begin
				stall = 0;
			end
			if (stall == 0) begin
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end
		end
	end

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
		req_bus.valid   <= 1'b1;
		req_bus.cmd     <= cmd;
		req_bus.byte_in <= b;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		if (!calm && $urandom_range(7) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(posedge clk);
		end
	endtask

	task automatic push_string(input int unsigned len);
		repeat (len) send_beat(CMD_PUSH, 8'($urandom_range(255, 1)));
		send_beat(CMD_PUSH, 8'h00);
	endtask

	task automatic settle();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
	endtask

	task automatic write_cap(input logic [CAP_W-1:0] value);
		settle();
		// an open string may still be in flight without a result beat
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_traffic(input int unsigned n_items, input int unsigned max_len,
		input int unsigned push_pct);
		int unsigned done;
		int unsigned pick;
		int unsigned len;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			if (pick < push_pct) begin
				len = $urandom_range(max_len);
				push_string(len);
				done += len + 1;
			end else if (pick < 94) begin
				len = $urandom_range(max_len + 2, 1);
				repeat (len) send_beat(CMD_POP, 8'($urandom_range(255)));
				done += len;
			end else if (pick < 96) begin
				send_beat(CMD_CLEAR, 8'($urandom_range(255)));
				done++;
			end else if (pick < 98) begin
				send_beat(CMD_UNUSED, 8'($urandom_range(255)));
			end else begin
				// stray byte, may open or end a string anywhere
				send_beat(CMD_PUSH, 8'($urandom_range(255)));
				done++;
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		req_bus.valid   = 1'b0;
		req_bus.cmd     = CMD_PUSH;
		req_bus.byte_in = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, empty string, extremes of the byte
		send_beat(CMD_POP, 8'h00);
		send_beat(CMD_PUSH, 8'h00);
		send_beat(CMD_POP, 8'hff);
		send_beat(CMD_PUSH, 8'hff);
		send_beat(CMD_PUSH, 8'h01);
		send_beat(CMD_PUSH, 8'h00);
		repeat (3) send_beat(CMD_POP, 8'h00);
		send_beat(CMD_UNUSED, 8'haa);
		// pop while a string is open
		send_beat(CMD_PUSH, 8'h12);
		send_beat(CMD_POP, 8'h00);
		send_beat(CMD_PUSH, 8'h00);
		send_beat(CMD_CLEAR, 8'h00);

		// smallest ring: exact fit, then no room
		write_cap(CAP_W'(2));
		send_beat(CMD_PUSH, 8'h80);
		send_beat(CMD_PUSH, 8'h00);
		send_beat(CMD_PUSH, 8'h55);
		send_beat(CMD_PUSH, 8'h66);
		send_beat(CMD_PUSH, 8'h00);
		repeat (3) send_beat(CMD_POP, 8'h00);
		// clear drops the open string
		send_beat(CMD_PUSH, 8'h7f);
		send_beat(CMD_CLEAR, 8'h00);
		send_beat(CMD_PUSH, 8'h00);
		// register write drops the open string too
		send_beat(CMD_PUSH, 8'h33);
		write_cap(CAP_W'(3));
		send_beat(CMD_PUSH, 8'h00);
		send_beat(CMD_POP, 8'h00);

		write_cap(CAP_W'(0));
		random_traffic(150, 2, 50);
		write_cap(CAP_W'(1));
		random_traffic(80, 2, 50);
		write_cap(CAP_W'(5));
		random_traffic(75, 5, 50);
		settle();
		random_traffic(75, 5, 50);
		write_cap(CAP_W'(23));
		hold_req = 1'b1;
		random_traffic(200, 14, 55);
		write_cap(CAP_W'(2047));
		random_traffic(120, 40, 50);
		write_cap(CAP_W'(1025));
		random_traffic(40, 10, 50);
		write_cap(CAP_W'(1000));
		random_traffic(100, 20, 50);
		write_cap(CAP_W'(1024));
		calm = 1'b1;
		random_traffic(400, 30, 70);

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_string_record_ring_queue_top OK");
		else
			$display("tb_string_record_ring_queue_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

@@ string_record_ring_queue_top.f @@
+incdir+rtl/core
rtl/core/srrq_pkg.sv
rtl/core/srrq_ifs.sv
rtl/core/srrq_ring.sv
rtl/core/string_record_ring_queue_top.sv
sim/string_record_ring_queue_checker.sv
sim/tb_string_record_ring_queue_top.sv
